// ===== sv/dcrm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrm_pkg
// shared constants for the deflate checkpoint range mapper
// ----------------------------------------------------------------------------
package dcrm_pkg;
	localparam int FIELD_W = 40;
	localparam int DELTA_W = 16;
	localparam int HDR_W = 16;
	localparam logic [HDR_W-1:0] HDR_FETCH_RESET = 16'd200;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_REQ = 1'b1;
endpackage

// ===== sv/deflate_checkpoint_range_mapper_core.sv =====
// ----------------------------------------------------------------------------
// deflate_checkpoint_range_mapper_core
// checkpoint table and request to compressed fetch range mapping
// ----------------------------------------------------------------------------
// A load request appends one checkpoint to the table memory unless the
// table is full. A range request walks the table through its single read
// port, one entry per cycle, and the walk stops at the entry that closes the
// data range or at the last entry. It then hands out header, data and, for
// the last request, flushed ranges, each waiting while the output register
// is stalled. Configuration writes are always taken.
module deflate_checkpoint_range_mapper_core #(
	parameter int TABLE_DEPTH = 4096,
	parameter int OFFSET_BITS = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dcrm_pkg::HDR_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  kind,
	input  logic                                  first_entry,
	input  logic [dcrm_pkg::DELTA_W-1:0]          in_bits_delta,
	input  logic [dcrm_pkg::DELTA_W-1:0]          out_bytes_raw,
	input  logic [dcrm_pkg::FIELD_W-1:0]          want_start,
	input  logic [dcrm_pkg::FIELD_W-1:0]          want_end,
	input  logic                                  last_request,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dcrm_pkg::FIELD_W-1:0]          fetch_start,
	output logic [dcrm_pkg::FIELD_W-1:0]          fetch_end,
	output logic                                  failed,
	output logic                                  last
);
	import dcrm_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int OB = OFFSET_BITS;
	localparam int MW = 2 * OB + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FAIL  = 3'd2;
	localparam logic [2:0] S_HDR   = 3'd3;
	localparam logic [2:0] S_DATA  = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [MW-1:0] mem [TABLE_DEPTH];

	logic [2:0]       state_q;
	logic [HDR_W-1:0] hfb_q;
	logic [CW-1:0]    cnt_q;
	logic [OB-1:0]    sum_in_q, sum_out_q;
	logic [OB-1:0]    hsent_q, pend_s_q, pend_e_q;
	logic             pend_v_q, bfail_q;
	logic [FIELD_W-1:0] start_q, end_q;
	logic             lastreq_q;
	logic [CW-1:0]    ra_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	logic [MW-1:0]    rd_s1;
	logic             have_q, hdr_q;
	logic [OB-1:0]    lastblk_q, prev_in_q, zs_q, ze_q, hbits_q;

	logic             in_acc, slot_free, issue, emit;
	logic [CW-1:0]    cnt_eff;
	logic [OB-1:0]    sum_in_n, sum_out_n;
	logic [OB-1:0]    ent_in, ent_out;
	logic             ent_bs, past, is_last_ent;
	logic [OB-1:0]    push_s, push_e, hs;
	logic             merge;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign slot_free = !out_valid || !out_stall;
	assign issue = (state_q == S_SCAN) && (ra_q < cnt_q);

	assign cnt_eff = first_entry ? '0 : cnt_q;
	assign sum_in_n = (first_entry ? '0 : sum_in_q) + OB'(in_bits_delta);
	assign sum_out_n = (first_entry ? '0 : sum_out_q) + OB'(out_bytes_raw[DELTA_W-2:0]);

	assign ent_in = rd_s1[OB-1:0];
	assign ent_out = rd_s1[2*OB-1:OB];
	assign ent_bs = rd_s1[MW-1];
	assign past = 64'(start_q) < 64'(ent_out);
	assign is_last_ent = (CW'(idx_s1) + CW'(1)) == cnt_q;

	assign hs = hbits_q >> 3;
	always_comb begin
		if (state_q == S_HDR) begin
			push_s = hs;
			push_e = hs + OB'(hfb_q);
		end else begin
			push_s = zs_q >> 3;
			push_e = (ze_q >> 3) + OB'(ze_q[2:0] != 3'd0);
		end
	end
	assign merge = pend_v_q && (pend_e_q >= push_s);

	// a result is loaded into the output register this cycle
	assign emit = slot_free && ((state_q == S_FAIL) ||
		(((state_q == S_HDR && hdr_q) || state_q == S_DATA) && !merge && pend_v_q) ||
		(state_q == S_FLUSH && lastreq_q && pend_v_q));

	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_LOAD && cnt_eff != CW'(TABLE_DEPTH))
			mem[cnt_eff[AW-1:0]] <= {~out_bytes_raw[DELTA_W-1], sum_out_n, sum_in_n};
		rd_s1 <= mem[ra_q[AW-1:0]];
		idx_s1 <= ra_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hfb_q <= HDR_FETCH_RESET;
			cnt_q <= '0;
			sum_in_q <= '0;
			sum_out_q <= '0;
			hsent_q <= '0;
			pend_s_q <= '0;
			pend_e_q <= '0;
			pend_v_q <= 1'b0;
			bfail_q <= 1'b0;
			out_valid <= 1'b0;
			fetch_start <= '0;
			fetch_end <= '0;
			failed <= 1'b0;
			last <= 1'b0;
			start_q <= '0;
			end_q <= '0;
			lastreq_q <= 1'b0;
			vld_s1 <= 1'b0;
			ra_q <= '0;
			have_q <= 1'b0;
			hdr_q <= 1'b0;
			lastblk_q <= '0;
			prev_in_q <= '0;
			zs_q <= '0;
			ze_q <= '0;
			hbits_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				hfb_q <= cfg_data;
			if (emit)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			vld_s1 <= issue;
			if (issue)
				ra_q <= ra_q + CW'(1);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && kind == KIND_LOAD) begin
						if (cnt_eff != CW'(TABLE_DEPTH)) begin
							cnt_q <= cnt_eff + CW'(1);
							sum_in_q <= sum_in_n;
							sum_out_q <= sum_out_n;
						end
					end else if (in_acc) begin
						start_q <= want_start;
						end_q <= want_end;
						lastreq_q <= last_request;
						ra_q <= '0;
						have_q <= 1'b0;
						hdr_q <= 1'b0;
						lastblk_q <= '0;
						if (bfail_q) begin
							if (last_request) begin
								hsent_q <= '0;
								pend_s_q <= '0;
								pend_e_q <= '0;
								pend_v_q <= 1'b0;
								bfail_q <= 1'b0;
							end
						end else if (cnt_q == '0) begin
							state_q <= S_FAIL;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						prev_in_q <= ent_in;
						if (ent_bs)
							lastblk_q <= ent_in;
						if (past && !have_q) begin
							have_q <= 1'b1;
							zs_q <= prev_in_q;
							hdr_q <= (lastblk_q != hsent_q);
							hbits_q <= lastblk_q;
						end
						if (past && !have_q && idx_s1 == '0)
							state_q <= S_FAIL;
						else if (past && (64'(end_q) <= 64'(ent_out) || is_last_ent)) begin
							ze_q <= ent_in;
							state_q <= S_HDR;
						end else if (is_last_ent)
							state_q <= S_FAIL;
					end
				end
				S_FAIL: begin
					if (slot_free) begin
						fetch_start <= '0;
						fetch_end <= '0;
						failed <= 1'b1;
						last <= 1'b1;
						hsent_q <= '0;
						pend_s_q <= '0;
						pend_e_q <= '0;
						pend_v_q <= 1'b0;
						bfail_q <= !lastreq_q;
						state_q <= S_IDLE;
					end
				end
				S_HDR, S_DATA: begin
					if (state_q == S_HDR && !hdr_q) begin
						state_q <= S_DATA;
					end else if (slot_free) begin
						if (state_q == S_HDR)
							hsent_q <= hbits_q;
						if (merge) begin
							if (push_e > pend_e_q)
								pend_e_q <= push_e;
						end else begin
							if (pend_v_q) begin
								fetch_start <= FIELD_W'(pend_s_q);
								fetch_end <= FIELD_W'(pend_e_q);
								failed <= 1'b0;
								last <= 1'b0;
							end
							pend_s_q <= push_s;
							pend_e_q <= push_e;
							pend_v_q <= 1'b1;
						end
						state_q <= (state_q == S_HDR) ? S_DATA : S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!lastreq_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						if (pend_v_q) begin
							fetch_start <= FIELD_W'(pend_s_q);
							fetch_end <= FIELD_W'(pend_e_q);
							failed <= 1'b0;
							last <= 1'b1;
						end
						hsent_q <= '0;
						pend_s_q <= '0;
						pend_e_q <= '0;
						pend_v_q <= 1'b0;
						bfail_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == S_IDLE)
		else $error("request taken while busy");
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cnt_q != '0)
		else $error("table walk on empty table");
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> last)
		else $error("failure result not marked last");
	a_ra_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> ra_q <= cnt_q)
		else $error("read address past table end");
endmodule
